[rtl/core/gift64_pkg.sv]
// shared types, tables and round functions for the gift-64 cipher
package gift64_pkg;

	localparam int BLOCK_W = 64;
	localparam int KEY_W   = 128;
	localparam int RC_W    = 6;

	// configuration register indexes
	localparam logic REG_KEY_HIGH = 1'b0;
	localparam logic REG_KEY_LOW  = 1'b1;

	// direction codes
	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	typedef logic [BLOCK_W-1:0] block_t;
	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [RC_W-1:0]    rc_t;

	// one slot of the round pipeline
	typedef struct packed {
		logic   valid;
		logic   op;
		block_t block;
	} stage_t;

	localparam logic [3:0] SBOX_FWD [16] = '{
		4'h1, 4'ha, 4'h4, 4'hc, 4'h6, 4'hf, 4'h3, 4'h9,
		4'h2, 4'hd, 4'hb, 4'h7, 4'h5, 4'h0, 4'h8, 4'he};

	localparam logic [3:0] SBOX_INV [16] = '{
		4'hd, 4'h0, 4'h8, 4'h6, 4'h2, 4'hc, 4'h4, 4'hb,
		4'he, 4'h7, 4'h1, 4'ha, 4'h3, 4'h9, 4'hf, 4'h5};

	localparam logic [5:0] BIT_DEST [64] = '{
		6'd0,  6'd17, 6'd34, 6'd51, 6'd48, 6'd1,  6'd18, 6'd35,
		6'd32, 6'd49, 6'd2,  6'd19, 6'd16, 6'd33, 6'd50, 6'd3,
		6'd4,  6'd21, 6'd38, 6'd55, 6'd52, 6'd5,  6'd22, 6'd39,
		6'd36, 6'd53, 6'd6,  6'd23, 6'd20, 6'd37, 6'd54, 6'd7,
		6'd8,  6'd25, 6'd42, 6'd59, 6'd56, 6'd9,  6'd26, 6'd43,
		6'd40, 6'd57, 6'd10, 6'd27, 6'd24, 6'd41, 6'd58, 6'd11,
		6'd12, 6'd29, 6'd46, 6'd63, 6'd60, 6'd13, 6'd30, 6'd47,
		6'd44, 6'd61, 6'd14, 6'd31, 6'd28, 6'd45, 6'd62, 6'd15};

	function automatic block_t sub_fwd(input block_t x);
		block_t y;
		y = '0;
		for (int i = 0; i < 16; i++) begin
			y[4*i +: 4] = SBOX_FWD[x[4*i +: 4]];
		end
		return y;
	endfunction

	function automatic block_t sub_inv(input block_t x);
		block_t y;
		y = '0;
		for (int i = 0; i < 16; i++) begin
			y[4*i +: 4] = SBOX_INV[x[4*i +: 4]];
		end
		return y;
	endfunction

	function automatic block_t perm_fwd(input block_t x);
		block_t y;
		y = '0;
		for (int i = 0; i < BLOCK_W; i++) begin
			y[BIT_DEST[i]] = x[i];
		end
		return y;
	endfunction

	function automatic block_t perm_inv(input block_t x);
		block_t y;
		y = '0;
		for (int i = 0; i < BLOCK_W; i++) begin
			y[i] = x[BIT_DEST[i]];
		end
		return y;
	endfunction

	function automatic rc_t rc_next(input rc_t c);
		return {c[4:0], c[5] ^ c[4] ^ 1'b1};
	endfunction

	function automatic logic [15:0] ror16(input logic [15:0] v, input int n);
		return (v >> n) | (v << (16 - n));
	endfunction

	// k7..k0 <- (k1 >>> 2), (k0 >>> 12), k7..k2
	function automatic key_t key_update(input key_t k);
		return {ror16(k[31:16], 2), ror16(k[15:0], 12), k[127:32]};
	endfunction

	function automatic block_t round_mask(input logic [15:0] u, input logic [15:0] v,
			input rc_t c);
		block_t m;
		m = {1'b1, {(BLOCK_W-1){1'b0}}};
		for (int i = 0; i < 16; i++) begin
			m[4*i+1] = m[4*i+1] ^ u[i];
			m[4*i]   = m[4*i] ^ v[i];
		end
		m[23] = m[23] ^ c[5];
		m[19] = m[19] ^ c[4];
		m[15] = m[15] ^ c[3];
		m[11] = m[11] ^ c[2];
		m[7]  = m[7] ^ c[1];
		m[3]  = m[3] ^ c[0];
		return m;
	endfunction

endpackage

[rtl/core/gift64_if.sv]
// valid/ready channels for input blocks and result blocks
interface gift64_in_if;
	logic                     valid;
	logic                     ready;
	logic                     op;
	logic [63:0]              block_in;

	modport source (output valid, output op, output block_in, input ready);
	modport sink   (input valid, input op, input block_in, output ready);
endinterface

interface gift64_out_if;
	logic                     valid;
	logic                     ready;
	logic [63:0]              block_out;

	modport source (output valid, output block_out, input ready);
	modport sink   (input valid, input block_out, output ready);
endinterface

[rtl/core/gift64_block_cipher.sv]
// gift-64 block cipher top level: key schedule and a chain of round cells
// Each round has its own registered cell and a new block, encrypt or decrypt in
// any mix, can enter every cycle while results are taken. The chain moves as one:
// when a finished block is not taken the whole chain holds and the input is not
// ready. Keys are to be written through the plain write port (index 0 key_high,
// index 1 key_low) while no transaction is in flight; this is not enforced.
module gift64_block_cipher #(
	parameter int ROUND_COUNT = 28
) (
	input  logic               clk,
	input  logic               arst_n,
	gift64_in_if.sink          req,
	gift64_out_if.source       rsp,
	input  logic               wr_en,
	input  logic               wr_index,
	input  logic [63:0]        wr_data
);
	import gift64_pkg::*;

	block_t                   mask [ROUND_COUNT];
	stage_t                   chain [ROUND_COUNT+1];
	logic [ROUND_COUNT-1:0]   stage_valid;
	logic                     adv;

	gift64_key_sched #(
		.ROUND_COUNT (ROUND_COUNT)
	) u_key_sched (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.mask     (mask)
	);

	assign adv       = !chain[ROUND_COUNT].valid || rsp.ready;
	assign req.ready = adv;

	assign chain[0].valid = req.valid;
	assign chain[0].op    = req.op;
	assign chain[0].block = req.block_in;

	for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_cell
		gift64_round_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.enc_mask (mask[i]),
			.dec_mask (mask[ROUND_COUNT-1-i]),
			.prev     (chain[i]),
			.next     (chain[i+1])
		);
		assign stage_valid[i] = chain[i+1].valid;
	end

	assign rsp.valid     = chain[ROUND_COUNT].valid;
	assign rsp.block_out = chain[ROUND_COUNT].block;

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |-> !req.ready)
		else $error("input taken while result stalled");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(stage_valid))
		else $error("pipeline moved while stalled");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> stage_valid[0])
		else $error("accepted transaction not in first cell");

	a_idle_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !req.valid |=> !stage_valid[0])
		else $error("first cell filled without a transaction");

endmodule

[rtl/core/gift64_key_sched.sv]
// key registers and the unrolled key schedule giving one mask per round
module gift64_key_sched #(
	parameter int ROUND_COUNT = 28
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic                  wr_index,
	input  logic [63:0]           wr_data,
	output gift64_pkg::block_t    mask [ROUND_COUNT]
);
	import gift64_pkg::*;

	logic [63:0] key_high_q;
	logic [63:0] key_low_q;
	key_t        ks [ROUND_COUNT];
	rc_t         rc [ROUND_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_KEY_HIGH: key_high_q <= wr_data;
				REG_KEY_LOW:  key_low_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// the key schedule is rotations and word moves only, so it is pure wiring; constants and masks are combinational
	for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
		if (r == 0) begin : g_first
			assign ks[r] = {key_high_q, key_low_q};
			assign rc[r] = rc_next('0);
		end else begin : g_next
			assign ks[r] = key_update(ks[r-1]);
			assign rc[r] = rc_next(rc[r-1]);
		end
		assign mask[r] = round_mask(ks[r][31:16], ks[r][15:0], rc[r]);
	end

endmodule

[rtl/core/gift64_round_cell.sv]
// one round of either direction, with its pipeline slot
module gift64_round_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  gift64_pkg::block_t    enc_mask,
	input  gift64_pkg::block_t    dec_mask,
	input  gift64_pkg::stage_t    prev,
	output gift64_pkg::stage_t    next
);
	import gift64_pkg::*;

	logic   valid_q;
	logic   op_q;
	block_t block_q;
	block_t enc_res;
	block_t dec_res;

	assign enc_res = perm_fwd(sub_fwd(prev.block)) ^ enc_mask;
	assign dec_res = sub_inv(perm_inv(prev.block ^ dec_mask));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_q    <= prev.op;
			block_q <= (prev.op == OP_DECRYPT) ? dec_res : enc_res;
		end
	end

	assign next = '{valid: valid_q, op: op_q, block: block_q};

endmodule
